// File: rtl/assert_macros.svh
// Assertion macros used by the checker file erld_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ERLD_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Check that a condition in one cycle implies another in the next cycle.
`define ERLD_ASSERT_NEXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// File: rtl/erld_pkg.sv
`default_nettype none

package erld_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int RUN_W   = 9;
    localparam int COUNT_W = 16;

    // Register file
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [0:0] REG_ESCAPE_BYTE  = 1'b0;
    localparam logic [0:0] REG_OUTPUT_LIMIT = 1'b1;

    // A repeat count of zero stands for a full run
    localparam logic [RUN_W-1:0] FULL_RUN = 9'd256;

    // Classified payload byte passed from the front end to the back end
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_esc;
        logic              is_zero;
        logic              last;
    } tok_t;

endpackage

`default_nettype wire

// File: rtl/erld_fifo.sv
`default_nettype none

module erld_fifo #(
    parameter int DEPTH = 2
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push_valid,
    output logic                push_ready,
    input  erld_pkg::tok_t      push_tok,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output erld_pkg::tok_t      pop_tok
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    erld_pkg::tok_t    entry_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              push;
    logic              pop;

    // Flag occupancy
    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_tok    = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

`default_nettype wire

// File: rtl/erld_front.sv
`default_nettype none

module erld_front (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [erld_pkg::BYTE_W-1:0]  payload_byte,
    input  wire                          payload_end,
    input  wire  [erld_pkg::BYTE_W-1:0]  escape_byte,
    output logic                         tok_valid,
    input  wire                          tok_ready,
    output erld_pkg::tok_t               tok
);

    logic            valid_reg;
    logic            valid_next;
    erld_pkg::tok_t  tok_reg;
    logic            accept;

    // Take a byte whenever the stage is empty or draining
    assign in_ready  = !valid_reg || tok_ready;
    assign accept    = in_valid && in_ready;
    assign tok_valid = valid_reg;
    assign tok       = tok_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (tok_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Classify the byte against the escape code and zero
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tok_reg.data    <= payload_byte;
            tok_reg.is_esc  <= (payload_byte == escape_byte);
            tok_reg.is_zero <= (payload_byte == '0);
            tok_reg.last    <= payload_end;
        end
    end

endmodule

`default_nettype wire

// File: rtl/erld_back.sv
`default_nettype none

module erld_back (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           tok_valid,
    output logic                          tok_ready,
    input  erld_pkg::tok_t                tok,
    input  wire  [erld_pkg::COUNT_W-1:0]  output_limit,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [erld_pkg::BYTE_W-1:0]   run_value,
    output logic [erld_pkg::RUN_W-1:0]    run_length,
    output logic                          limit_reached,
    output logic                          truncated_escape,
    output logic                          payload_done
);

    localparam int CW = erld_pkg::COUNT_W;
    localparam int RW = erld_pkg::RUN_W;
    localparam int BW = erld_pkg::BYTE_W;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_VAL  = 2'd2;

    logic [1:0]     phase_reg;
    logic [1:0]     phase_next;
    logic [BW-1:0]  held_reg;
    logic [BW-1:0]  held_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [BW-1:0]  run_value_reg;
    logic [RW-1:0]  run_length_reg;
    logic           limit_reached_reg;
    logic           truncated_reg;
    logic           done_reg;

    logic           pop;
    logic           active;
    logic [RW-1:0]  want;
    logic [RW-1:0]  clipped;
    logic [BW-1:0]  value;
    logic [BW-1:0]  value_out;
    logic [CW-1:0]  room;
    logic [CW-1:0]  count_sum;

    assign tok_ready        = !out_valid_reg || out_ready;
    assign pop              = tok_valid && tok_ready;
    assign out_valid        = out_valid_reg;
    assign run_value        = run_value_reg;
    assign run_length       = run_length_reg;
    assign limit_reached    = limit_reached_reg;
    assign truncated_escape = truncated_reg;
    assign payload_done     = done_reg;

    // Decode one token against the escape phase
    always_comb
    begin
        want       = '0;
        value      = '0;
        phase_next = phase_reg;
        held_next  = held_reg;
        active     = (count_reg < output_limit);
        if (active)
        begin
            case (phase_reg)
                PH_ESC:
                begin
                    if (tok.is_esc)
                    begin
                        value      = tok.data;
                        want       = RW'(1);
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        held_next  = tok.data;
                        phase_next = PH_VAL;
                    end
                end
                PH_VAL:
                begin
                    value      = held_reg;
                    want       = tok.is_zero ? erld_pkg::FULL_RUN : RW'(tok.data);
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    if (tok.is_esc)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        value      = tok.data;
                        want       = RW'(1);
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end
    end

    // Clip the run at the output limit and advance the count
    always_comb
    begin
        room      = output_limit - count_reg;
        clipped   = (CW'(want) > room) ? room[RW-1:0] : want;
        value_out = (clipped == '0) ? '0 : value;
        count_sum = count_reg + CW'(clipped);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        count_next = count_reg;
        if (pop)
        begin
            count_next = tok.last ? '0 : count_sum;
        end
    end

    // Hold decode state and drop it at the end of a payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            held_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            if (pop)
            begin
                phase_reg <= tok.last ? PH_IDLE : phase_next;
                held_reg  <= tok.last ? '0 : held_next;
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            run_value_reg     <= value_out;
            run_length_reg    <= clipped;
            limit_reached_reg <= (count_sum >= output_limit);
            truncated_reg     <= tok.last && (phase_next != PH_IDLE);
            done_reg          <= tok.last;
        end
    end

endmodule

`default_nettype wire

// File: rtl/escape_byte_rle_decoder.sv
// Escape-byte run-length decoder.
// Input channel: in_valid/in_ready with payload_byte and payload_end; a byte
// transfers when both are high. payload_end marks the last byte of a payload.
// Output channel: out_valid/out_ready with one run per input byte: run_value,
// run_length (0 = nothing, up to 256), limit_reached, truncated_escape and
// payload_done, which closes the payload.
// Registers over the APB port: escape_byte at 0x0, output_limit at 0x4; write
// them only while no byte is in flight.
// Path: a byte passes the classify stage, then the queue, then the decode
// stage with its output register.
// Throughput: one byte per cycle while the receiver keeps out_ready high,
// set by the decode loop of phase and output count in the back end.
// Reset clears both registers, the decode state, the queue and all valids.
// When the receiver stalls the result holds; the queue between the front and
// back ends absorbs QUEUE_DEPTH bytes plus one in the front stage before
// in_ready drops.
`default_nettype none

module escape_byte_rle_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire  [erld_pkg::BYTE_W-1:0]        payload_byte,
    input  wire                                payload_end,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [erld_pkg::BYTE_W-1:0]        run_value,
    output logic [erld_pkg::RUN_W-1:0]         run_length,
    output logic                               limit_reached,
    output logic                               truncated_escape,
    output logic                               payload_done,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [erld_pkg::ADDR_W-1:0]        paddr,
    input  wire  [erld_pkg::DATA_W-1:0]        pwdata,
    output logic [erld_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    logic [erld_pkg::BYTE_W-1:0]   escape_byte_reg;
    logic [erld_pkg::COUNT_W-1:0]  output_limit_reg;
    logic                          cfg_write;
    logic [0:0]                    reg_index;

    erld_pkg::tok_t  front_tok;
    logic            front_valid;
    logic            front_ready;
    erld_pkg::tok_t  back_tok;
    logic            back_valid;
    logic            back_ready;

    // Decode the register port
    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (reg_index)
            erld_pkg::REG_ESCAPE_BYTE:  prdata = erld_pkg::DATA_W'(escape_byte_reg);
            erld_pkg::REG_OUTPUT_LIMIT: prdata = erld_pkg::DATA_W'(output_limit_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_byte_reg  <= '0;
            output_limit_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                erld_pkg::REG_ESCAPE_BYTE:
                    escape_byte_reg <= pwdata[erld_pkg::BYTE_W-1:0];
                erld_pkg::REG_OUTPUT_LIMIT:
                    output_limit_reg <= pwdata[erld_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Classify incoming bytes
    erld_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .payload_byte (payload_byte),
        .payload_end  (payload_end),
        .escape_byte  (escape_byte_reg),
        .tok_valid    (front_valid),
        .tok_ready    (front_ready),
        .tok          (front_tok)
    );

    // Decouple the two ends
    erld_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_tok   (front_tok),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_tok    (back_tok)
    );

    // Expand tokens into clipped runs
    erld_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .tok_valid        (back_valid),
        .tok_ready        (back_ready),
        .tok              (back_tok),
        .output_limit     (output_limit_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .run_value        (run_value),
        .run_length       (run_length),
        .limit_reached    (limit_reached),
        .truncated_escape (truncated_escape),
        .payload_done     (payload_done)
    );

endmodule

`default_nettype wire

// File: rtl/erld_checker.sv
`default_nettype none
`include "assert_macros.svh"

module erld_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        out_valid,
    input wire        out_ready,
    input wire [7:0]  run_value,
    input wire [8:0]  run_length,
    input wire        limit_reached,
    input wire        truncated_escape,
    input wire        payload_done
);

    // A run never exceeds a full repeat
    `ERLD_ASSERT(a_run_range, clk, rst_n, !out_valid || run_length <= 9'd256)

    // An empty run carries a zero value
    `ERLD_ASSERT(a_empty_zero, clk, rst_n, !out_valid || run_length != 9'd0 || run_value == 8'd0)

    // A dropped escape sequence is reported only at payload end
    `ERLD_ASSERT(a_trunc_end, clk, rst_n, !out_valid || !truncated_escape || payload_done)

    // A stalled result holds
    `ERLD_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(run_value) && $stable(run_length) && $stable(limit_reached) && $stable(truncated_escape) && $stable(payload_done))

endmodule

bind escape_byte_rle_decoder erld_checker u_erld_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .run_value        (run_value),
    .run_length       (run_length),
    .limit_reached    (limit_reached),
    .truncated_escape (truncated_escape),
    .payload_done     (payload_done)
);

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int QUIET_CYCLES = 6;
    localparam int IDLE_ITEMS   = 1250;
    localparam int TOTAL_ITEMS  = 1550;

    localparam int BYTE_W  = erld_pkg::BYTE_W;
    localparam int RUN_W   = erld_pkg::RUN_W;
    localparam int COUNT_W = erld_pkg::COUNT_W;
    localparam int ADDR_W  = erld_pkg::ADDR_W;
    localparam int DATA_W  = erld_pkg::DATA_W;

    // Decoder phase as tracked by the predictor
    typedef enum logic [1:0] {
        PH_OPEN    = 2'd0,
        PH_ESCAPED = 2'd1,
        PH_VALUE   = 2'd2
    } dec_phase_t;

    // One decoded run as seen on the output channel
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [RUN_W-1:0]  length;
        logic              limit_hit;
        logic              trunc_esc;
        logic              done;
    } run_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                in_valid;
    logic                in_ready;
    logic [BYTE_W-1:0]   payload_byte;
    logic                payload_end;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [BYTE_W-1:0]   run_value;
    logic [RUN_W-1:0]    run_length;
    logic                limit_reached;
    logic                truncated_escape;
    logic                payload_done;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Predictor copy of registers and decode state
    logic [BYTE_W-1:0]   cfg_escape;
    logic [COUNT_W-1:0]  cfg_limit;
    dec_phase_t          dec_phase;
    logic [BYTE_W-1:0]   dec_held;
    logic [COUNT_W-1:0]  dec_count;

    run_t pending_runs[$];
    int   items_sent;
    int   fail_count;
    int   cycle_count = 0;
    int   stall_left = 0;
    bit   idle_on;

    escape_byte_rle_decoder i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .payload_byte     (payload_byte),
        .payload_end      (payload_end),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .run_value        (run_value),
        .run_length       (run_length),
        .limit_reached    (limit_reached),
        .truncated_escape (truncated_escape),
        .payload_done     (payload_done),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    // Decode one payload byte and advance the predictor state
    function automatic run_t decode_byte(input logic [BYTE_W-1:0] b, input logic last);
        run_t             r;
        int unsigned      want;
        int unsigned      room;
        logic [BYTE_W-1:0] value;
        want  = 0;
        value = '0;
        if (dec_count < cfg_limit)
        begin
            case (dec_phase)
                PH_ESCAPED:
                begin
                    if (b == cfg_escape)
                    begin
                        value     = b;
                        want      = 1;
                        dec_phase = PH_OPEN;
                    end
                    else
                    begin
                        dec_held  = b;
                        dec_phase = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    value     = dec_held;
                    want      = (b != 0) ? int'(b) : int'(erld_pkg::FULL_RUN);
                    dec_phase = PH_OPEN;
                end
                default:
                begin
                    dec_phase = PH_OPEN;
                    if (b == cfg_escape)
                    begin
                        dec_phase = PH_ESCAPED;
                    end
                    else
                    begin
                        value = b;
                        want  = 1;
                    end
                end
            endcase
        end
        // Clip the run at the remaining room
        room = int'(cfg_limit) - int'(dec_count);
        if (want > room)
        begin
            want = room;
        end
        if (want == 0)
        begin
            value = '0;
        end
        dec_count   = dec_count + COUNT_W'(want);
        r.value     = value;
        r.length    = RUN_W'(want);
        r.limit_hit = (dec_count >= cfg_limit);
        r.trunc_esc = last && (dec_phase != PH_OPEN);
        r.done      = last;
        if (last)
        begin
            dec_phase = PH_OPEN;
            dec_held  = '0;
            dec_count = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        fail_count++;
    endtask

    // Send one payload byte; returns at the edge of its transfer
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 99) < 12)
        begin
            gap = int'($urandom_range(1, 11));
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        payload_byte <= b;
        payload_end  <= last;
        do @(posedge clk); while (!in_ready);
        pending_runs.push_back(decode_byte(b, last));
        items_sent++;
    endtask

    // Hold off input until every expected run has been checked
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_runs.size() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle until pready, then idle
    task automatic write_reg(input logic [0:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == erld_pkg::REG_ESCAPE_BYTE)
        begin
            cfg_escape = value[BYTE_W-1:0];
        end
        else
        begin
            cfg_limit = value[COUNT_W-1:0];
        end
        @(posedge clk);
    endtask

    task automatic set_config(input logic [BYTE_W-1:0] esc, input logic [COUNT_W-1:0] lim);
        wait_quiet();
        write_reg(erld_pkg::REG_ESCAPE_BYTE, DATA_W'(esc));
        write_reg(erld_pkg::REG_OUTPUT_LIMIT, DATA_W'(lim));
    endtask

    // Reset registers: zero limit, so every byte is ignored
    task automatic test_zero_limit();
        send_byte(8'h00, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Literals, escaped escape and repeat runs, including count zero
    task automatic test_runs();
        set_config(8'hAA, 16'hFFFF);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h37, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b1);
    endtask

    // Payload ending after the escape and after the value byte
    task automatic test_truncation();
        send_byte(8'hAA, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h10, 1'b1);
    endtask

    // Change the escape byte while a sequence is open
    task automatic test_escape_rewrite();
        send_byte(8'hAA, 1'b0);
        wait_quiet();
        write_reg(erld_pkg::REG_ESCAPE_BYTE, 32'h55);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b0);
        wait_quiet();
        write_reg(erld_pkg::REG_ESCAPE_BYTE, 32'h00);
        send_byte(8'h00, 1'b1);
    endtask

    // Run clipped at the limit, bytes past the limit, limit lowered mid-payload
    task automatic test_limit();
        set_config(8'hFF, 16'd5);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h03, 1'b1);
        set_config(8'hFF, 16'd100);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        wait_quiet();
        write_reg(erld_pkg::REG_OUTPUT_LIMIT, 32'd2);
        send_byte(8'hFF, 1'b1);
    endtask

    // Build one payload from random tokens, with noise and truncated endings
    task automatic send_payload();
        logic [BYTE_W-1:0] bytes[$];
        logic [BYTE_W-1:0] b;
        int                ntok;
        int                kind;
        bit                cut;
        ntok = int'($urandom_range(1, 24));
        cut  = 1'b0;
        for (int t = 0; t < ntok && !cut; t++)
        begin
            kind = int'($urandom_range(0, 99));
            if (kind < 50)
            begin
                b = BYTE_W'($urandom_range(0, 255));
                if (b == cfg_escape)
                begin
                    b = b ^ 8'h01;
                end
                bytes.push_back(b);
            end
            else if (kind < 60)
            begin
                bytes.push_back(cfg_escape);
                bytes.push_back(cfg_escape);
            end
            else if (kind < 85)
            begin
                bytes.push_back(cfg_escape);
                bytes.push_back(BYTE_W'($urandom_range(0, 255)));
                case ($urandom_range(0, 5))
                    0: bytes.push_back(8'h00);
                    1: bytes.push_back(8'hFF);
                    default: bytes.push_back(BYTE_W'($urandom_range(1, 40)));
                endcase
            end
            else if (kind < 95)
            begin
                bytes.push_back(BYTE_W'($urandom_range(0, 255)));
            end
            else
            begin
                // End the payload inside an escape sequence
                bytes.push_back(cfg_escape);
                if ($urandom_range(0, 1))
                begin
                    bytes.push_back(BYTE_W'($urandom_range(0, 255)));
                end
                cut = 1'b1;
            end
        end
        foreach (bytes[k])
        begin
            send_byte(bytes[k], k == bytes.size() - 1);
        end
    endtask

    // Random settings and payloads until the item goal is reached
    task automatic test_random_payloads(input int goal);
        logic [BYTE_W-1:0]  esc;
        logic [COUNT_W-1:0] lim;
        while (items_sent < goal)
        begin
            case ($urandom_range(0, 5))
                0: esc = 8'h00;
                1: esc = 8'hFF;
                default: esc = BYTE_W'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 9))
                0: lim = 16'd0;
                1: lim = 16'hFFFF;
                2, 3: lim = COUNT_W'($urandom_range(1, 16));
                4, 5: lim = COUNT_W'($urandom_range(17, 600));
                default: lim = COUNT_W'($urandom_range(601, 65535));
            endcase
            set_config(esc, lim);
            repeat ($urandom_range(2, 6)) send_payload();
        end
    endtask

    // Receiver stalls in random bursts while idling is on
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 99) < 12)
        begin
            out_ready  <= 1'b0;
            stall_left <= int'($urandom_range(0, 10));
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Compare each transfer on the output channel with the oldest expectation
    always @(posedge clk)
    begin
        run_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_runs.size() == 0)
            begin
                report_mismatch("result with no expectation waiting");
            end
            else
            begin
                want = pending_runs.pop_front();
                if (run_value !== want.value)
                    report_mismatch($sformatf("run_value got %0h, expected %0h",
                                              run_value, want.value));
                if (run_length !== want.length)
                    report_mismatch($sformatf("run_length got %0d, expected %0d",
                                              run_length, want.length));
                if (limit_reached !== want.limit_hit)
                    report_mismatch($sformatf("limit_reached got %b, expected %b",
                                              limit_reached, want.limit_hit));
                if (truncated_escape !== want.trunc_esc)
                    report_mismatch($sformatf("truncated_escape got %b, expected %b",
                                              truncated_escape, want.trunc_esc));
                if (payload_done !== want.done)
                    report_mismatch($sformatf("payload_done got %b, expected %b",
                                              payload_done, want.done));
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        payload_byte <= '0;
        payload_end  <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        cfg_escape   = '0;
        cfg_limit    = '0;
        dec_phase    = PH_OPEN;
        dec_held     = '0;
        dec_count    = '0;
        items_sent   = 0;
        fail_count   = 0;
        idle_on      = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_limit();
        test_runs();
        test_truncation();
        test_escape_rewrite();
        test_limit();
        test_random_payloads(IDLE_ITEMS);
        idle_on = 1'b0;
        test_random_payloads(TOTAL_ITEMS);

        wait_quiet();
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
